>>> rtl/a2r_pkg.sv
// ----------------------------------------------------------------------------
// a2r_pkg
// Types and constants shared by the atan2 rational approximation pipeline.
// ----------------------------------------------------------------------------
package a2r_pkg;

   localparam int IN_W      = 16;           // input component width
   localparam int MAG_W     = IN_W;         // magnitude width, holds 2^(IN_W-1)
   localparam int RATIO_W   = 16;           // Q0.16 ratio
   localparam int ANG_FRAC  = 13;           // output fraction bits
   localparam int ANG_W     = ANG_FRAC + 3; // Q3.13 angle
   localparam int POLY_W    = 32;           // Horner terms and denominator
   localparam int PROD_W    = RATIO_W + POLY_W;
   localparam int QUOT_W    = 30;           // base angle, Q.30, below 1.0
   localparam int RES_W     = 32;           // reflected angle, Q.30, below 4.0
   localparam int RND_SHIFT = 30 - ANG_FRAC;

   // Coefficients, unsigned Q.30
   localparam logic [POLY_W-1:0] K1 = 32'd338;
   localparam logic [POLY_W-1:0] K2 = 32'd1073713441;
   localparam logic [POLY_W-1:0] K3 = 32'd158312570;
   localparam logic [POLY_W-1:0] K4 = 32'd332840025;
   localparam logic [POLY_W-1:0] K5 = 32'd54011108;
   localparam logic [POLY_W-1:0] K6 = 32'd157951624;
   localparam logic [POLY_W-1:0] K7 = 32'd691988024;

   localparam logic [POLY_W-1:0] Q30_ONE     = 32'd1073741824;
   localparam logic [RES_W-1:0]  Q30_PI      = 32'd3373259426;
   localparam logic [RES_W-1:0]  Q30_HALF_PI = 32'd1686629713;

   // Input and result words
   typedef struct packed {
      logic signed [IN_W-1:0] y_value;
      logic signed [IN_W-1:0] x_value;
   } req_type;

   typedef struct packed {
      logic signed [ANG_W-1:0] angle;
      logic                    degenerate;
   } rsp_type;

   // Per-word control carried alongside the datapath
   typedef struct packed {
      logic yneg;   // y below zero: negate at the end
      logic xneg;   // x below zero: reflect about pi
      logic ygt;    // |y| > |x|: reflect about pi/2
      logic degen;  // larger magnitude under threshold
      logic rzero;  // zero divisor: ratio forced to 0
      logic rsat;   // equal magnitudes: ratio saturates
   } side_type;

endpackage

>>> rtl/a2r_ratio_div.sv
// ----------------------------------------------------------------------------
// a2r_ratio_div
// Pipelined restoring divider, one quotient bit per stage: min*2^16 / max
// with min < max, or min == max flagged for saturation by the caller.
// ----------------------------------------------------------------------------
module a2r_ratio_div
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [a2r_pkg::MAG_W-1:0]     in_num,
   input  logic [a2r_pkg::MAG_W-1:0]     in_den,
   input  a2r_pkg::side_type             in_side,
   output logic                          out_valid,
   output logic [a2r_pkg::RATIO_W-1:0]   out_quot,
   output a2r_pkg::side_type             out_side
);
   import a2r_pkg::*;

   logic               vld_ff  [0:RATIO_W-1];
   logic [MAG_W-1:0]   rem_ff  [0:RATIO_W-1];
   logic [MAG_W-1:0]   den_ff  [0:RATIO_W-1];
   logic [RATIO_W-1:0] quo_ff  [0:RATIO_W-1];
   side_type           side_ff [0:RATIO_W-1];

   for (genvar i = 0; i < RATIO_W; i++) begin : g_stage
      logic             vld_in;
      logic [MAG_W-1:0] rem_prev;
      logic [MAG_W-1:0] den_in;
      logic [RATIO_W-1:0] quo_prev;
      side_type         side_in;
      logic [MAG_W:0]   shl;
      logic             ge;
      logic [MAG_W-1:0] rem_in;
      logic [RATIO_W-1:0] quo_in;

      if (i == 0) begin : g_first
         assign vld_in   = in_valid;
         assign rem_prev = in_num;
         assign den_in   = in_den;
         assign quo_prev = '0;
         assign side_in  = in_side;
      end else begin : g_next
         assign vld_in   = vld_ff[i-1];
         assign rem_prev = rem_ff[i-1];
         assign den_in   = den_ff[i-1];
         assign quo_prev = quo_ff[i-1];
         assign side_in  = side_ff[i-1];
      end

      // shift in one bit, subtract when it fits
      always_comb begin
         shl    = {rem_prev, 1'b0};
         ge     = (shl >= {1'b0, den_in});
         rem_in = ge ? MAG_W'(shl - {1'b0, den_in}) : shl[MAG_W-1:0];
         quo_in = {quo_prev[RATIO_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else begin
            vld_ff[i] <= vld_in;
         end
         rem_ff[i]  <= rem_in;
         den_ff[i]  <= den_in;
         quo_ff[i]  <= quo_in;
         side_ff[i] <= side_in;
      end
   end

   assign out_valid = vld_ff[RATIO_W-1];
   assign out_quot  = quo_ff[RATIO_W-1];
   assign out_side  = side_ff[RATIO_W-1];

endmodule

>>> rtl/a2r_poly.sv
// ----------------------------------------------------------------------------
// a2r_poly
// Horner evaluation of the numerator and denominator polynomials in the
// ratio. Multiply and add stages alternate: eight register stages.
// ----------------------------------------------------------------------------
module a2r_poly
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [a2r_pkg::RATIO_W-1:0]   in_ratio,
   input  a2r_pkg::side_type             in_side,
   output logic                          out_valid,
   output logic [a2r_pkg::POLY_W-1:0]    out_num,
   output logic [a2r_pkg::POLY_W-1:0]    out_den,
   output a2r_pkg::side_type             out_side
);
   import a2r_pkg::*;

   localparam int NSTG = 8;

   logic               vld_ff  [0:NSTG-1];
   side_type           side_ff [0:NSTG-1];
   logic [RATIO_W-1:0] r_ff    [0:NSTG-1];
   // even stages hold products, odd stages hold sums
   logic [PROD_W-1:0]  pa_ff   [0:NSTG-1];
   logic [PROD_W-1:0]  pb_ff   [0:NSTG-1];
   logic [POLY_W-1:0]  ta_ff   [0:NSTG-1];
   logic [POLY_W-1:0]  tb_ff   [0:NSTG-1];

   function automatic logic [PROD_W-1:0] mul(input logic [RATIO_W-1:0] r,
                                             input logic [POLY_W-1:0] c);
      return {{POLY_W{1'b0}}, r} * {{RATIO_W{1'b0}}, c};
   endfunction

   function automatic logic [POLY_W-1:0] hi(input logic [PROD_W-1:0] p);
      return p[PROD_W-1:RATIO_W];
   endfunction

   // control and ratio shift line
   for (genvar i = 0; i < NSTG; i++) begin : g_ctl
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else begin
            vld_ff[i] <= (i == 0) ? in_valid : vld_ff[(i == 0) ? 0 : i-1];
         end
         side_ff[i] <= (i == 0) ? in_side  : side_ff[(i == 0) ? 0 : i-1];
         r_ff[i]    <= (i == 0) ? in_ratio : r_ff[(i == 0) ? 0 : i-1];
      end
   end

   // stage 0: r*K5, r*K7
   always_ff @(posedge clock) begin
      pa_ff[0] <= mul(in_ratio, K5);
      pb_ff[0] <= mul(in_ratio, K7);
      ta_ff[0] <= '0;
      tb_ff[0] <= '0;
   end

   // stage 1: innermost terms
   always_ff @(posedge clock) begin
      ta_ff[1] <= K4 - hi(pa_ff[0]);
      tb_ff[1] <= K6 + hi(pb_ff[0]);
      pa_ff[1] <= '0;
      pb_ff[1] <= '0;
   end

   // stage 2: multiply both by r
   always_ff @(posedge clock) begin
      pa_ff[2] <= mul(r_ff[1], ta_ff[1]);
      pb_ff[2] <= mul(r_ff[1], tb_ff[1]);
      ta_ff[2] <= '0;
      tb_ff[2] <= '0;
   end

   // stage 3: numerator step, denominator finished
   always_ff @(posedge clock) begin
      ta_ff[3] <= K3 + hi(pa_ff[2]);
      tb_ff[3] <= Q30_ONE + hi(pb_ff[2]);
      pa_ff[3] <= '0;
      pb_ff[3] <= '0;
   end

   // stages 4..7: two more numerator steps, denominator rides along
   always_ff @(posedge clock) begin
      pa_ff[4] <= mul(r_ff[3], ta_ff[3]);
      tb_ff[4] <= tb_ff[3];
      ta_ff[5] <= K2 + hi(pa_ff[4]);
      tb_ff[5] <= tb_ff[4];
      pa_ff[6] <= mul(r_ff[5], ta_ff[5]);
      tb_ff[6] <= tb_ff[5];
      ta_ff[7] <= K1 + hi(pa_ff[6]);
      tb_ff[7] <= tb_ff[6];
      pb_ff[4] <= '0;
      ta_ff[4] <= '0;
      pa_ff[5] <= '0;
      pb_ff[5] <= '0;
      pb_ff[6] <= '0;
      ta_ff[6] <= '0;
      pa_ff[7] <= '0;
      pb_ff[7] <= '0;
   end

   assign out_valid = vld_ff[NSTG-1];
   assign out_side  = side_ff[NSTG-1];
   assign out_num   = ta_ff[NSTG-1];
   assign out_den   = tb_ff[NSTG-1];

endmodule

>>> rtl/a2r_angle_div.sv
// ----------------------------------------------------------------------------
// a2r_angle_div
// Pipelined restoring divider for the base angle: N*2^30 / D, N < D,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module a2r_angle_div
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [a2r_pkg::POLY_W-1:0]    in_num,
   input  logic [a2r_pkg::POLY_W-1:0]    in_den,
   input  a2r_pkg::side_type             in_side,
   output logic                          out_valid,
   output logic [a2r_pkg::QUOT_W-1:0]    out_quot,
   output a2r_pkg::side_type             out_side
);
   import a2r_pkg::*;

   logic              vld_ff  [0:QUOT_W-1];
   logic [POLY_W-1:0] rem_ff  [0:QUOT_W-1];
   logic [POLY_W-1:0] den_ff  [0:QUOT_W-1];
   logic [QUOT_W-1:0] quo_ff  [0:QUOT_W-1];
   side_type          side_ff [0:QUOT_W-1];

   for (genvar i = 0; i < QUOT_W; i++) begin : g_stage
      logic              vld_in;
      logic [POLY_W-1:0] rem_prev;
      logic [POLY_W-1:0] den_in;
      logic [QUOT_W-1:0] quo_prev;
      side_type          side_in;
      logic [POLY_W:0]   shl;
      logic              ge;
      logic [POLY_W-1:0] rem_in;
      logic [QUOT_W-1:0] quo_in;

      if (i == 0) begin : g_first
         assign vld_in   = in_valid;
         assign rem_prev = in_num;
         assign den_in   = in_den;
         assign quo_prev = '0;
         assign side_in  = in_side;
      end else begin : g_next
         assign vld_in   = vld_ff[i-1];
         assign rem_prev = rem_ff[i-1];
         assign den_in   = den_ff[i-1];
         assign quo_prev = quo_ff[i-1];
         assign side_in  = side_ff[i-1];
      end

      // shift in one bit, subtract when it fits
      always_comb begin
         shl    = {rem_prev, 1'b0};
         ge     = (shl >= {1'b0, den_in});
         rem_in = ge ? POLY_W'(shl - {1'b0, den_in}) : shl[POLY_W-1:0];
         quo_in = {quo_prev[QUOT_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else begin
            vld_ff[i] <= vld_in;
         end
         rem_ff[i]  <= rem_in;
         den_ff[i]  <= den_in;
         quo_ff[i]  <= quo_in;
         side_ff[i] <= side_in;
      end
   end

   assign out_valid = vld_ff[QUOT_W-1];
   assign out_quot  = quo_ff[QUOT_W-1];
   assign out_side  = side_ff[QUOT_W-1];

endmodule

>>> rtl/atan2_rational_approx.sv
// ----------------------------------------------------------------------------
// atan2_rational_approx
// Four-quadrant arctangent of a signed (y, x) pair, Q3.13 radians, through a
// ratio divider, a rational polynomial and a base-angle divider.
//
//   channel  ports                      direction  handshake
//   request  start, busy, req_data      in         start & !busy
//   result   rsp_valid, rsp_data        out        one-cycle strobe
//   config   csr_wr_en, csr_wr_data     in         write on csr_wr_en
//
// One word per cycle through a front stage, 16 ratio divider stages,
// 8 polynomial stages, 30 angle divider stages and 2 output stages.
// The dividers resolve one quotient bit per stage and set the depth.
// busy stays low; reset clears all valid bits and sets the threshold to 1.
// The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module atan2_rational_approx
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  a2r_pkg::req_type           req_data,
   output logic                       rsp_valid,
   output a2r_pkg::rsp_type           rsp_data,
   input  logic                       csr_wr_en,
   input  logic [a2r_pkg::IN_W-1:0]   csr_wr_data
);
   import a2r_pkg::*;

   // threshold register
   logic [IN_W-1:0] thr_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= IN_W'(1);
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   assign busy = 1'b0;

   // front stage: magnitudes, compare, flags
   logic             fr_vld_ff;
   logic [MAG_W-1:0] fr_mn_ff, fr_mx_ff;
   side_type         fr_side_ff;
   logic [MAG_W-1:0] ay, ax, mx_in, mn_in;
   side_type         side_in;

   always_comb begin
      ay = req_data.y_value[IN_W-1] ? MAG_W'(-req_data.y_value) : MAG_W'(req_data.y_value);
      ax = req_data.x_value[IN_W-1] ? MAG_W'(-req_data.x_value) : MAG_W'(req_data.x_value);
      side_in.yneg  = req_data.y_value[IN_W-1];
      side_in.xneg  = req_data.x_value[IN_W-1];
      side_in.ygt   = (ay > ax);
      mx_in         = side_in.ygt ? ay : ax;
      mn_in         = side_in.ygt ? ax : ay;
      side_in.degen = (mx_in < thr_ff);
      side_in.rzero = (mx_in == '0);
      side_in.rsat  = (mx_in == mn_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_vld_ff <= 1'b0;
      end else begin
         fr_vld_ff <= start & ~busy;
      end
      fr_mn_ff   <= mn_in;
      fr_mx_ff   <= mx_in;
      fr_side_ff <= side_in;
   end

   // ratio divider
   logic               rd_vld;
   logic [RATIO_W-1:0] rd_quot;
   side_type           rd_side;
   logic [RATIO_W-1:0] ratio;

   a2r_ratio_div u_ratio_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_vld_ff),
      .in_num    (fr_mn_ff),
      .in_den    (fr_mx_ff),
      .in_side   (fr_side_ff),
      .out_valid (rd_vld),
      .out_quot  (rd_quot),
      .out_side  (rd_side)
   );

   // zero divisor gives 0, equal magnitudes saturate
   always_comb begin
      if (rd_side.rzero) begin
         ratio = '0;
      end else if (rd_side.rsat) begin
         ratio = '1;
      end else begin
         ratio = rd_quot;
      end
   end

   // polynomials
   logic              pl_vld;
   logic [POLY_W-1:0] pl_num, pl_den;
   side_type          pl_side;

   a2r_poly u_poly (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rd_vld),
      .in_ratio  (ratio),
      .in_side   (rd_side),
      .out_valid (pl_vld),
      .out_num   (pl_num),
      .out_den   (pl_den),
      .out_side  (pl_side)
   );

   // base angle divider
   logic              ad_vld;
   logic [QUOT_W-1:0] ad_quot;
   side_type          ad_side;

   a2r_angle_div u_angle_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pl_vld),
      .in_num    (pl_num),
      .in_den    (pl_den),
      .in_side   (pl_side),
      .out_valid (ad_vld),
      .out_quot  (ad_quot),
      .out_side  (ad_side)
   );

   // octant and quadrant reflections
   logic             rf_vld_ff;
   logic [RES_W-1:0] rf_res_ff;
   side_type         rf_side_ff;
   logic [RES_W-1:0] res_a, res_in;

   always_comb begin
      res_a  = ad_side.ygt ? (Q30_HALF_PI - RES_W'(ad_quot)) : RES_W'(ad_quot);
      res_in = ad_side.xneg ? (Q30_PI - res_a) : res_a;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rf_vld_ff <= 1'b0;
      end else begin
         rf_vld_ff <= ad_vld;
      end
      rf_res_ff  <= res_in;
      rf_side_ff <= ad_side;
   end

   // round half up, apply sign, output register
   logic             out_vld_ff;
   rsp_type          out_ff;
   rsp_type          out_in;
   logic [RES_W-1:0] rounded;
   logic [ANG_W-1:0] mag;

   always_comb begin
      rounded = rf_res_ff + (RES_W'(1) << (RND_SHIFT - 1));
      mag     = ANG_W'(rounded >> RND_SHIFT);
      if (rf_side_ff.degen) begin
         out_in.angle      = '0;
         out_in.degenerate = 1'b1;
      end else begin
         out_in.angle      = rf_side_ff.yneg ? $signed(-mag) : $signed(mag);
         out_in.degenerate = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= rf_vld_ff;
      end
      out_ff <= out_in;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

endmodule

>>> dv/atan2_checker.sv
// ----------------------------------------------------------------------------
// atan2_checker
// Watches the request and result channels of the atan2 block, predicts each
// angle word from the coordinate pair and the current threshold, and compares
// the results in order against the predictions.
// ----------------------------------------------------------------------------
module atan2_checker
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  a2r_pkg::req_type            req_data,
   input  logic                        rsp_valid,
   input  a2r_pkg::rsp_type            rsp_data,
   input  logic                        csr_wr_en,
   input  logic [a2r_pkg::IN_W-1:0]    csr_wr_data,
   output int                          fail_count,
   output int                          angles_pending
);
   import a2r_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   rsp_type          angle_queue[$];
   logic [IN_W-1:0]  threshold;

   // magnitude of a signed component; the most negative value stays exact
   function automatic logic [63:0] comp_mag(logic [IN_W-1:0] v);
      return v[IN_W-1] ? 64'((~v) + 1'b1) & 64'hFFFF : 64'(v);
   endfunction

   // base angle in Q.30 for a Q0.16 ratio
   function automatic logic [63:0] poly_angle(logic [63:0] r);
      logic [63:0] t;
      logic [63:0] d;
      t = 64'(K4) - ((r * 64'(K5)) >> 16);
      t = 64'(K3) + ((r * t) >> 16);
      t = 64'(K2) + ((r * t) >> 16);
      t = 64'(K1) + ((r * t) >> 16);
      d = 64'(Q30_ONE) + ((r * (64'(K6) + ((r * 64'(K7)) >> 16))) >> 16);
      return (t << 30) / d;
   endfunction

   function automatic rsp_type predict_angle(req_type w, logic [IN_W-1:0] thr);
      rsp_type     o;
      logic [63:0] ay, ax, mx, mn, r, a, m;
      ay = comp_mag(w.y_value);
      ax = comp_mag(w.x_value);
      mx = (ay > ax) ? ay : ax;
      mn = (ay > ax) ? ax : ay;
      o = '0;
      if (mx < 64'(thr)) begin
         o.degenerate = 1'b1;
         return o;
      end
      r = (mx == 0) ? 64'd0 : (mn << 16) / mx;
      if (r > 64'd65535) r = 64'd65535;
      a = poly_angle(r);
      if (ay > ax) a = 64'(Q30_HALF_PI) - a;
      if (w.x_value[IN_W-1]) a = 64'(Q30_PI) - a;
      m = (a + (64'd1 << (RND_SHIFT - 1))) >> RND_SHIFT;
      o.angle = w.y_value[IN_W-1] ? ANG_W'(64'd0 - m) : ANG_W'(m);
      return o;
   endfunction

   // track threshold, queue predictions, check results
   always @(posedge clock) begin
      rsp_type exp_word;
      if (reset) begin
         threshold <= 16'd1;
         angle_queue.delete();
      end else begin
         if (start && !busy) angle_queue.push_back(predict_angle(req_data, threshold));
         if (rsp_valid) begin
            if (angle_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected word: angle %0d degen %0b",
                           rsp_data.angle, rsp_data.degenerate);
            end else begin
               exp_word = angle_queue.pop_front();
               if (rsp_data.angle !== exp_word.angle ||
                   rsp_data.degenerate !== exp_word.degenerate) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: exp angle %0d degen %0b, got angle %0d degen %0b",
                              exp_word.angle, exp_word.degenerate,
                              rsp_data.angle, rsp_data.degenerate);
               end
            end
         end
         if (csr_wr_en) threshold <= csr_wr_data;
      end
      angles_pending = angle_queue.size();
   end

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives coordinate pairs into the atan2 block with directed corners, then
// random pairs with bursty idle gaps, across several threshold settings. The
// checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
   import a2r_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY   = 57;
   localparam int CYCLE_MAX = 400000;

   logic            clock, reset, start, busy, rsp_valid, csr_wr_en;
   logic [IN_W-1:0] csr_wr_data;
   req_type         req_data;
   rsp_type         rsp_data;
   int              fail_count, angles_pending, cycle_count;
   bit              allow_idle;

   atan2_rational_approx uut (.*);

   atan2_checker chk (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_MAX) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // one word, with an optional idle burst before it
   task automatic send_word(logic [15:0] y, logic [15:0] x);
      int gap;
      if (allow_idle && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 17);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= {y, x};
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // drain, then write the threshold while the pipe is empty
   task automatic set_threshold(logic [IN_W-1:0] v);
      start <= 1'b0;
      @(posedge clock);
      while (angles_pending != 0) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [15:0] rand_comp(int thr);
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($signed($urandom_range(0, 2 * thr + 2)) - thr - 1);
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      int          thr_set[5];
      logic [15:0] y;
      start = 0; req_data = '0; csr_wr_en = 0; csr_wr_data = '0; allow_idle = 1;
      reset = 1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed corners at reset threshold
      send_word(16'd0, 16'd0);
      send_word(16'd0, 16'd100);
      send_word(16'd0, 16'hFF9C);
      send_word(16'd100, 16'd0);
      send_word(16'hFF9C, 16'd0);
      send_word(16'd500, 16'd500);
      send_word(16'hFE0C, 16'hFE0C);
      send_word(16'h8000, 16'h8000);
      send_word(16'h8000, 16'h7FFF);
      send_word(16'h7FFF, 16'h8000);
      send_word(16'h7FFF, 16'h7FFF);
      send_word(16'h0001, 16'h8000);
      send_word(16'hFFFF, 16'h8000);
      send_word(16'h8000, 16'd0);
      send_word(16'd1, 16'd2);
      send_word(16'hFFFF, 16'hFFFF);

      // zero threshold: all-zero pair goes through the divider
      set_threshold(16'd0);
      send_word(16'd0, 16'd0);
      send_word(16'd0, 16'h8000);
      // threshold 0x8000: everything but full-scale negatives degenerate
      set_threshold(16'h8000);
      send_word(16'h7FFF, 16'h7FFF);
      send_word(16'h8000, 16'd3);
      send_word(16'd5, 16'h8000);

      thr_set = '{1, 0, 32768, 200, 65535};
      foreach (thr_set[i]) begin
         set_threshold(16'(thr_set[i]));
         for (int n = 0; n < 170; n++) begin
            if (i == 4 && n >= 100) allow_idle = 0;
            y = rand_comp(thr_set[i] > 1000 ? 300 : thr_set[i]);
            send_word(y, rand_comp(thr_set[i] > 1000 ? 300 : thr_set[i]));
         end
      end
      start <= 1'b0;

      @(posedge clock);
      while (angles_pending != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (fail_count == 0 && rsp_valid === 1'b0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule
